[hw/rtl/esd_pkg.sv]
// Shared types, character constants and helper functions of the escape sequence decoder.
package esd_pkg;

  localparam int unsigned MaxRes        = 3;
  localparam int unsigned CntW          = $clog2(MaxRes + 1);
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [7:0] CharBsl   = 8'h5C;
  localparam logic [7:0] CharN     = 8'h6E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharThree = 8'h33;
  localparam logic [7:0] CharX     = 8'h78;
  localparam logic [7:0] CharXUp   = 8'h58;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharEsc   = 8'h1B;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BSL  = 3'd1,
    MODE_Z0   = 3'd2,
    MODE_Z03  = 3'd3,
    MODE_X0   = 3'd4,
    MODE_X1   = 3'd5
  } esd_mode_e;

  typedef struct packed {
    logic [MaxRes-1:0][7:0] data;
    logic [CntW-1:0]        cnt;
    logic                   bare;
    logic                   last;
  } esd_bundle_t;

  typedef struct packed {
    logic ok;
    logic [3:0] val;
  } esd_hex_t;

  function automatic esd_bundle_t emit_byte(esd_bundle_t b, logic [7:0] v);
    esd_bundle_t r;
    r = b;
    if (b.cnt < CntW'(MaxRes)) begin
      r.data[b.cnt] = v;
      r.cnt         = b.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic esd_hex_t hex_decode(logic [7:0] c);
    esd_hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end
    return h;
  endfunction

  // A character outside any escape: a backslash opens one, anything else is passed on.
  function automatic esd_bundle_t plain_byte(esd_bundle_t b, logic [7:0] c);
    esd_bundle_t r;
    r = b;
    if (c != CharBsl) begin
      r = emit_byte(b, c);
    end
    return r;
  endfunction

endpackage

[hw/rtl/esd_front.sv]
// Front end of the escape sequence decoder: escape state machine and result bundle builder.
module esd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          char_i,
  input  logic                end_i,
  output esd_pkg::esd_bundle_t bundle_o,
  output logic                bundle_valid_o
);
  import esd_pkg::*;

  esd_mode_e   mode_q, mode_d;
  logic [3:0]  fdv_q, fdv_d;
  logic        fdok_q, fdok_d;
  esd_mode_e   mode_step;
  logic [3:0]  fdv_step;
  logic        fdok_step;
  esd_hex_t    hex;
  logic [7:0]  hex_res;
  esd_bundle_t b;

  assign hex = hex_decode(char_i);

  always_comb begin
    hex_res = 8'd0;
    if (fdok_q) begin
      hex_res = hex.ok ? {fdv_q, hex.val} : {4'd0, fdv_q};
    end
  end

  // The step values hold the state after the character, before the end of string clears it.
  always_comb begin
    mode_step = mode_q;
    fdv_step  = fdv_q;
    fdok_step = fdok_q;
    case (mode_q)
      MODE_BSL: begin
        mode_step = MODE_IDLE;
        if (char_i == CharZero) begin
          mode_step = MODE_Z0;
        end else if (char_i == CharX || char_i == CharXUp) begin
          mode_step = MODE_X0;
        end
      end
      MODE_Z0: begin
        if (char_i == CharThree) begin
          mode_step = MODE_Z03;
        end else begin
          mode_step = (char_i == CharBsl) ? MODE_BSL : MODE_IDLE;
        end
      end
      MODE_Z03: begin
        mode_step = (char_i == CharBsl) ? MODE_BSL : MODE_IDLE;
      end
      MODE_X0: begin
        fdv_step  = hex.val;
        fdok_step = hex.ok;
        mode_step = MODE_X1;
      end
      MODE_X1: begin
        fdv_step  = 4'd0;
        fdok_step = 1'b0;
        mode_step = MODE_IDLE;
      end
      default: begin
        mode_step = (char_i == CharBsl) ? MODE_BSL : MODE_IDLE;
      end
    endcase

    mode_d = mode_step;
    fdv_d  = fdv_step;
    fdok_d = fdok_step;
    if (end_i) begin
      mode_d = MODE_IDLE;
      fdv_d  = 4'd0;
      fdok_d = 1'b0;
    end
  end

  always_comb begin
    b = '0;
    case (mode_q)
      MODE_BSL: begin
        if (char_i == CharN) begin
          b = emit_byte(b, CharLf);
        end else if (char_i != CharZero && char_i != CharX && char_i != CharXUp) begin
          b = emit_byte(b, char_i);
        end
      end
      MODE_Z0: begin
        if (char_i != CharThree) begin
          b = emit_byte(b, CharZero);
          b = plain_byte(b, char_i);
        end
      end
      MODE_Z03: begin
        if (char_i == CharThree) begin
          b = emit_byte(b, CharEsc);
        end else begin
          b = emit_byte(b, CharZero);
          b = emit_byte(b, CharThree);
          b = plain_byte(b, char_i);
        end
      end
      MODE_X0: ;
      MODE_X1: b = emit_byte(b, hex_res);
      default: b = plain_byte(b, char_i);
    endcase

    if (end_i) begin
      case (mode_step)
        MODE_Z0: b = emit_byte(b, CharZero);
        MODE_Z03: begin
          b = emit_byte(b, CharZero);
          b = emit_byte(b, CharThree);
        end
        MODE_X0: b = emit_byte(b, 8'd0);
        MODE_X1: b = emit_byte(b, fdok_step ? {4'd0, fdv_step} : 8'd0);
        default: ;
      endcase
      if (b.cnt == '0) begin
        b.cnt  = CntW'(1);
        b.bare = 1'b1;
      end
      b.last = 1'b1;
    end
  end

  assign bundle_o       = b;
  assign bundle_valid_o = accept_i && (b.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      fdv_q  <= 4'd0;
      fdok_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      fdv_q  <= fdv_d;
      fdok_q <= fdok_d;
    end
  end

  a_end_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_i |=> mode_q == MODE_IDLE && !fdok_q)
    else $error("decoder state not cleared after end of string");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_i |-> bundle_valid_o && bundle_o.last)
    else $error("end of string produced no final result");

endmodule

[hw/rtl/esd_fifo.sv]
// Short bundle queue between the front end and the back end of the escape sequence decoder.
module esd_fifo #(
  parameter int unsigned Depth = esd_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  esd_pkg::esd_bundle_t wdata_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output esd_pkg::esd_bundle_t rdata_o,
  output logic                 empty_o
);
  import esd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  esd_bundle_t      mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillW'(Depth));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(Depth))
    else $error("queue fill level exceeds depth");

  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> fill_q == $past(fill_q) + 1'b1)
    else $error("queue fill level lost a transaction");

endmodule

[hw/rtl/esd_back.sv]
// Back end of the escape sequence decoder: hands out the bytes of each queued bundle one at a time.
module esd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  esd_pkg::esd_bundle_t head_i,
  input  logic                 head_empty_i,
  output logic                 head_pop_o,
  input  logic                 pop,
  output logic                 empty,
  output logic [7:0]           char_out_o,
  output logic                 byte_valid_o,
  output logic                 run_last_o
);
  import esd_pkg::*;

  logic [CntW-1:0] idx_q, idx_d;
  logic            at_tail;
  logic            take;

  assign empty        = head_empty_i;
  assign take         = pop && !head_empty_i;
  assign at_tail      = (idx_q == head_i.cnt - 1'b1);
  assign head_pop_o   = take && at_tail;
  assign char_out_o   = head_i.data[idx_q];
  assign byte_valid_o = !head_i.bare;
  assign run_last_o   = head_i.last && at_tail;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = at_tail ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_empty_i |-> idx_q < head_i.cnt)
    else $error("byte index beyond bundle size");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_empty_i |-> idx_q == '0)
    else $error("byte index not rewound with empty queue");

endmodule

[hw/rtl/escape_sequence_decoder.sv]
// Results are registered in the bundle queue as their characters are accepted.
// Throughput: one character per cycle while each yields at most one byte and pop
// stays high; a character yielding more bytes is held in the queue, one pop per byte.
// Input is refused only when the bundle queue (QueueDepth entries) is full.
// Reset: asynchronous, active low; clears the escape state and empties the queue.
// Top level of the escape sequence decoder.
module escape_sequence_decoder #(
  parameter int unsigned QueueDepth = esd_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  input  logic       string_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_out_o,
  output logic       byte_valid_o,
  output logic       run_last_o
);
  import esd_pkg::*;

  esd_bundle_t front_bundle;
  esd_bundle_t head_bundle;
  logic        front_valid;
  logic        accept;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  esd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .char_i         (char_in_i),
    .end_i          (string_end_i),
    .bundle_o       (front_bundle),
    .bundle_valid_o (front_valid)
  );

  esd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_bundle),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (head_bundle),
    .empty_o (q_empty)
  );

  esd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_bundle),
    .head_empty_i (q_empty),
    .head_pop_o   (q_pop),
    .pop          (pop),
    .empty        (empty),
    .char_out_o   (char_out_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o)
  );

endmodule

[bench/tb_escape_sequence_decoder.sv]
// Self-checking testbench of the escape sequence decoder: a directed table, then random strings.
`timescale 1ns / 100ps

module tb_escape_sequence_decoder;
  import esd_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       bv;
    logic       last;
  } decoded_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    logic       has_res;
    decoded_t   want;
  } row_t;

  localparam int unsigned NumChars = 330;
  localparam decoded_t NoByte = '{8'h00, 1'b0, 1'b0};

  localparam row_t DirectedRows [25] = '{
    '{8'h01,     1'b0, 1'b1, 1'b1, '{8'h01, 1'b1, 1'b0}},
    '{8'hFF,     1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{CharBsl,   1'b0, 1'b1, 1'b0, NoByte},
    '{CharN,     1'b0, 1'b1, 1'b1, '{CharLf, 1'b1, 1'b0}},
    '{CharBsl,   1'b0, 1'b0, 1'b0, NoByte},
    '{CharZero,  1'b0, 1'b0, 1'b0, NoByte},
    '{CharThree, 1'b0, 1'b0, 1'b0, NoByte},
    '{CharThree, 1'b0, 1'b1, 1'b1, '{CharEsc, 1'b1, 1'b0}},
    '{CharBsl,   1'b0, 1'b0, 1'b0, NoByte},
    '{CharZero,  1'b0, 1'b0, 1'b0, NoByte},
    '{CharThree, 1'b0, 1'b0, 1'b0, NoByte},
    '{CharBsl,   1'b0, 1'b0, 1'b0, NoByte},
    '{CharX,     1'b0, 1'b0, 1'b0, NoByte},
    '{8'h46,     1'b0, 1'b0, 1'b0, NoByte},
    '{8'h2B,     1'b0, 1'b0, 1'b0, NoByte},
    '{CharBsl,   1'b0, 1'b0, 1'b0, NoByte},
    '{CharXUp,   1'b0, 1'b0, 1'b0, NoByte},
    '{8'h67,     1'b0, 1'b0, 1'b0, NoByte},
    '{8'h31,     1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{CharBsl,   1'b0, 1'b0, 1'b0, NoByte},
    '{CharZero,  1'b0, 1'b0, 1'b0, NoByte},
    '{8'h41,     1'b1, 1'b0, 1'b0, NoByte},
    '{CharBsl,   1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{CharBsl,   1'b0, 1'b0, 1'b0, NoByte},
    '{CharX,     1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] char_in_i;
  logic       string_end_i;
  logic       empty;
  logic       pop;
  logic [7:0] char_out_o;
  logic       byte_valid_o;
  logic       run_last_o;

  escape_sequence_decoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .char_in_i    (char_in_i),
    .string_end_i (string_end_i),
    .empty        (empty),
    .pop          (pop),
    .char_out_o   (char_out_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o)
  );

  esd_mode_e  dec_mode;
  logic [3:0] dig_val;
  logic       dig_ok;
  decoded_t   step_out[$];
  decoded_t   pending_q[$];
  logic [7:0] text_q[$];
  logic       steady;
  int         hold_cnt;
  int         n_errors;
  int         n_chars;
  int         n_strings;
  int         n_results;
  int         n_bare;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", pending_q.size());
    $display("tb_escape_sequence_decoder NOT OK");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic void hex_digit(input logic [7:0] c, output logic ok, output logic [3:0] v);
    ok = 1'b1;
    v  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) v = c[3:0] + 4'd9;
    else ok = 1'b0;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    if (step_out.size() < MaxRes) step_out.push_back('{b, 1'b1, 1'b0});
  endfunction

  function automatic void put_plain(logic [7:0] c);
    dec_mode = MODE_IDLE;
    if (c == CharBsl) dec_mode = MODE_BSL;
    else put_byte(c);
  endfunction

  function automatic logic [7:0] hex_pair(logic second_ok, logic [3:0] second);
    if (!dig_ok) return 8'h00;
    if (second_ok) return {dig_val, second};
    return {4'h0, dig_val};
  endfunction

  // Decodes one character and leaves the bytes it yields in step_out.
  function automatic void decode_char(logic [7:0] c, logic fin);
    logic       ok;
    logic [3:0] v;
    decoded_t   tail;
    step_out.delete();
    case (dec_mode)
      MODE_BSL: begin
        dec_mode = MODE_IDLE;
        if (c == CharN) put_byte(CharLf);
        else if (c == CharZero) dec_mode = MODE_Z0;
        else if (c == CharX || c == CharXUp) dec_mode = MODE_X0;
        else put_byte(c);
      end
      MODE_Z0: begin
        if (c == CharThree) begin
          dec_mode = MODE_Z03;
        end else begin
          put_byte(CharZero);
          put_plain(c);
        end
      end
      MODE_Z03: begin
        if (c == CharThree) begin
          dec_mode = MODE_IDLE;
          put_byte(CharEsc);
        end else begin
          put_byte(CharZero);
          put_byte(CharThree);
          put_plain(c);
        end
      end
      MODE_X0: begin
        hex_digit(c, ok, v);
        dig_val  = v;
        dig_ok   = ok;
        dec_mode = MODE_X1;
      end
      MODE_X1: begin
        hex_digit(c, ok, v);
        put_byte(hex_pair(ok, v));
        dig_val  = 4'd0;
        dig_ok   = 1'b0;
        dec_mode = MODE_IDLE;
      end
      default: put_plain(c);
    endcase
    if (fin) begin
      case (dec_mode)
        MODE_Z0: put_byte(CharZero);
        MODE_Z03: begin
          put_byte(CharZero);
          put_byte(CharThree);
        end
        MODE_X0: put_byte(8'h00);
        MODE_X1: put_byte(hex_pair(1'b0, 4'd0));
        default: ;
      endcase
      dec_mode = MODE_IDLE;
      dig_val  = 4'd0;
      dig_ok   = 1'b0;
      if (step_out.size() == 0) step_out.push_back(NoByte);
      tail      = step_out.pop_back();
      tail.last = 1'b1;
      step_out.push_back(tail);
    end
  endfunction

  task automatic send_row(input row_t r);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    char_in_i    <= r.ch;
    string_end_i <= r.fin;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    decode_char(r.ch, r.fin);
    if (!r.typed) begin
      foreach (step_out[k]) pending_q.push_back(step_out[k]);
    end else if (r.has_res) begin
      pending_q.push_back(r.want);
    end
    n_chars++;
    if (r.fin) n_strings++;
  endtask

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] not_three();
    logic [7:0] c;
    do c = any_char(); while (c == CharThree);
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'h30 + 8'(r);
    if (r < 16) return 8'h61 + 8'(r - 10);
    return 8'h41 + 8'(r - 16);
  endfunction

  function automatic logic [7:0] x_char();
    return $urandom_range(0, 1) ? CharX : CharXUp;
  endfunction

  // Appends one escape or plain character to the string under construction.
  function automatic void add_token();
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 19);
    if (r <= 6) begin
      do c = any_char(); while (c == CharBsl);
      text_q.push_back(c);
      return;
    end
    text_q.push_back(CharBsl);
    case (r)
      7: text_q.push_back(CharN);
      8, 9: begin
        text_q.push_back(CharZero);
        text_q.push_back(CharThree);
        text_q.push_back(CharThree);
      end
      10: begin
        text_q.push_back(CharZero);
        text_q.push_back(not_three());
      end
      11: begin
        text_q.push_back(CharZero);
        text_q.push_back(CharThree);
        text_q.push_back(not_three());
      end
      12, 13: begin
        text_q.push_back(x_char());
        text_q.push_back($urandom_range(0, 4) != 0 ? hex_char() : any_char());
        text_q.push_back($urandom_range(0, 2) != 0 ? hex_char() : any_char());
      end
      14: begin
        text_q.push_back(x_char());
        text_q.push_back($urandom_range(0, 1) ? hex_char() : any_char());
      end
      15, 16: text_q.push_back(any_char());
      17: ;
      default: begin
        case ($urandom_range(0, 2))
          0: text_q.push_back(CharZero);
          1: begin
            text_q.push_back(CharZero);
            text_q.push_back(CharThree);
          end
          default: text_q.push_back(x_char());
        endcase
      end
    endcase
  endfunction

  function automatic void note_mismatch(string what, decoded_t want, decoded_t got);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%0t: %s: expected char %02h valid %0b last %0b, got char %02h valid %0b last %0b",
               $realtime, what, want.ch, want.bv, want.last, got.ch, got.bv, got.last);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    decoded_t got;
    decoded_t want;
    if (rst_ni && pop && !empty) begin
      got = '{char_out_o, byte_valid_o, run_last_o};
      n_results++;
      if (!got.bv) n_bare++;
      if (pending_q.size() == 0) begin
        note_mismatch("Unexpected transaction", NoByte, got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) note_mismatch("Result mismatch", want, got);
      end
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (!steady && $urandom_range(0, 2) == 0) hold_cnt = pick_gap();
    end
  end

  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    char_in_i    = 8'h20;
    string_end_i = 1'b0;
    dec_mode     = MODE_IDLE;
    dig_val      = 4'd0;
    dig_ok       = 1'b0;
    steady       = 1'b0;
    hold_cnt     = 0;
    n_errors     = 0;
    n_chars      = 0;
    n_strings    = 0;
    n_results    = 0;
    n_bare       = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) send_row(DirectedRows[i]);

    while (n_chars < NumChars) begin
      steady = ($urandom_range(0, 5) == 0);
      text_q.delete();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          text_q.push_back($urandom_range(0, 3) == 0 ? CharBsl : any_char());
        end
      end else begin
        repeat ($urandom_range(1, 8)) add_token();
      end
      foreach (text_q[i]) send_row('{text_q[i], i == text_q.size() - 1, 1'b0, 1'b0, NoByte});
    end
    push   <= 1'b0;
    steady = 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Decoded %0d characters in %0d strings into %0d results, %0d of them bare end markers.",
             n_chars, n_strings, n_results, n_bare);
    $display("Mismatches: %0d, results never seen: %0d.", n_errors, pending_q.size());
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("tb_escape_sequence_decoder OK");
    end else begin
      $display("tb_escape_sequence_decoder NOT OK");
    end
    $finish;
  end

endmodule
